// ===== src/bdpa_pkg.sv =====
// ----------------------------------------------------------------------------
// bdpa_pkg
// Types and constants shared by the delta patch applier modules.
// ----------------------------------------------------------------------------
package bdpa_pkg;

  localparam int unsigned ADDR_BITS_DEFAULT = 32;
  localparam int unsigned CTRL_BYTES        = 8;
  localparam int unsigned CTRL_VALUES       = 3;

  // Control byte index at which each value is complete
  localparam logic [4:0] IDX_DIFF_LAST  = 5'(CTRL_BYTES - 1);
  localparam logic [4:0] IDX_EXTRA_LAST = 5'(2 * CTRL_BYTES - 1);
  localparam logic [4:0] IDX_SEEK_LAST  = 5'(CTRL_VALUES * CTRL_BYTES - 1);
  localparam logic [2:0] POS_LAST       = 3'(CTRL_BYTES - 1);

  typedef enum logic [1:0] {
    PH_CTRL,
    PH_DIFF,
    PH_EXTRA
  } phase_e;

  // Block state apart from the source address, whose width is a parameter
  typedef struct packed {
    phase_e      phase;
    logic [4:0]  ctrl_idx;
    logic [63:0] ctrl_shift;
    logic [31:0] diff_rem;
    logic        diff_neg;
    logic        diff_big;
    logic [31:0] extra_rem;
    logic        extra_neg;
    logic        extra_big;
    logic [31:0] dest_offset;
    logic [31:0] patch_count;
    logic        error;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase:       PH_CTRL,
    ctrl_idx:    '0,
    ctrl_shift:  '0,
    diff_rem:    '0,
    diff_neg:    1'b0,
    diff_big:    1'b0,
    extra_rem:   '0,
    extra_neg:   1'b0,
    extra_big:   1'b0,
    dest_offset: '0,
    patch_count: '0,
    error:       1'b0
  };

  typedef struct packed {
    logic        dest_valid;
    logic [7:0]  dest_byte;
    logic        next_needs_src;
    logic [31:0] next_src_addr;
    logic        done_res;
    logic        status;
    logic [31:0] patch_bytes_used;
  } result_t;

endpackage

// ===== src/bdpa_in_if.sv =====
// ----------------------------------------------------------------------------
// bdpa_in_if
// Input channel: one patch byte and an optional source byte per item.
// ----------------------------------------------------------------------------
interface bdpa_in_if;

  logic       valid;
  logic       ready;
  logic [7:0] patch_byte;
  logic [7:0] src_byte;

  modport source (output valid, output patch_byte, output src_byte, input ready);
  modport sink   (input valid, input patch_byte, input src_byte, output ready);

endinterface

// ===== src/bdpa_out_if.sv =====
// ----------------------------------------------------------------------------
// bdpa_out_if
// Result channel: destination byte, source request and progress status.
// ----------------------------------------------------------------------------
interface bdpa_out_if;

  logic        valid;
  logic        ready;
  logic        dest_valid;
  logic [7:0]  dest_byte;
  logic        next_needs_src;
  logic [31:0] next_src_addr;
  logic        done_res;
  logic        status;
  logic [31:0] patch_bytes_used;

  modport source (
    output valid, output dest_valid, output dest_byte, output next_needs_src,
    output next_src_addr, output done_res, output status, output patch_bytes_used,
    input ready
  );
  modport sink (
    input valid, input dest_valid, input dest_byte, input next_needs_src,
    input next_src_addr, input done_res, input status, input patch_bytes_used,
    output ready
  );

endinterface

// ===== src/bdpa_step.sv =====
// ----------------------------------------------------------------------------
// bdpa_step
// Next-state and result logic for one patch byte: control gathering and
// validation, diff add, extra copy and the source seek at block end.
// ----------------------------------------------------------------------------
module bdpa_step
  import bdpa_pkg::*;
#(
  parameter int unsigned ADDR_BITS = ADDR_BITS_DEFAULT
) (
  input  state_t                 st_i,
  input  logic [ADDR_BITS-1:0]   addr_i,
  input  logic [31:0]            dest_size_i,
  input  logic [7:0]             patch_byte_i,
  input  logic [7:0]             src_byte_i,
  output state_t                 st_o,
  output logic [ADDR_BITS-1:0]   addr_o,
  output result_t                res_o
);

  logic                 done_now;
  logic [63:0]          value;
  logic [63:0]          seek_val;
  logic [63:0]          seek_mag;
  logic                 seek_neg;
  logic [ADDR_BITS-1:0] seek_addr;
  logic [ADDR_BITS-1:0] base_addr;
  logic [ADDR_BITS-1:0] fin_addr;
  logic [31:0]          room;
  logic [32:0]          need;
  logic                 bad;
  logic                 valid;
  logic [7:0]           byte_out;
  logic [63:0]          addr_ext;

  // Assemble the control value little-endian by shifting in from the top
  assign value = {patch_byte_i, st_i.ctrl_shift[63:8]};

  // Seek applied at block end: the fresh value when the block has no data
  assign seek_val  = (st_i.phase == PH_CTRL) ? value : st_i.ctrl_shift;
  assign seek_mag  = {1'b0, seek_val[62:0]};
  assign seek_neg  = seek_val[63] && (|seek_val[62:0]);
  assign seek_addr = seek_mag[ADDR_BITS-1:0];
  assign base_addr = (st_i.phase == PH_DIFF) ? addr_i + ADDR_BITS'(1) : addr_i;
  assign fin_addr  = seek_neg ? base_addr - seek_addr : base_addr + seek_addr;

  // Room left in the destination and the length the block asks for
  assign room = (dest_size_i > st_i.dest_offset) ? dest_size_i - st_i.dest_offset : '0;
  assign need = {1'b0, st_i.diff_rem} + {1'b0, st_i.extra_rem};
  assign bad  = st_i.diff_neg || st_i.diff_big || st_i.extra_neg || st_i.extra_big ||
                (need > {1'b0, room});

  assign done_now = (st_i.phase == PH_CTRL) && (st_i.ctrl_idx == '0) &&
                    (st_i.dest_offset >= dest_size_i);

  // Advance the state by one patch byte
  always_comb begin
    st_o     = st_i;
    addr_o   = addr_i;
    valid    = 1'b0;
    byte_out = '0;
    if (!st_i.error && !done_now) begin
      st_o.patch_count = st_i.patch_count + 32'd1;
      case (st_i.phase)
        PH_CTRL: begin
          st_o.ctrl_shift = value;
          if (st_i.ctrl_idx[2:0] != POS_LAST) begin
            st_o.ctrl_idx = st_i.ctrl_idx + 5'd1;
          end else if (st_i.ctrl_idx == IDX_DIFF_LAST) begin
            st_o.diff_rem = value[31:0];
            st_o.diff_neg = value[63] && (|value[62:0]);
            st_o.diff_big = |value[62:32];
            st_o.ctrl_idx = st_i.ctrl_idx + 5'd1;
          end else if (st_i.ctrl_idx == IDX_EXTRA_LAST) begin
            st_o.extra_rem = value[31:0];
            st_o.extra_neg = value[63] && (|value[62:0]);
            st_o.extra_big = |value[62:32];
            st_o.ctrl_idx  = st_i.ctrl_idx + 5'd1;
          end else begin
            st_o.ctrl_idx = IDX_SEEK_LAST;
            if (bad) begin
              st_o.error = 1'b1;
            end else begin
              st_o.diff_neg  = 1'b0;
              st_o.diff_big  = 1'b0;
              st_o.extra_neg = 1'b0;
              st_o.extra_big = 1'b0;
              if (st_i.diff_rem != '0) begin
                st_o.phase = PH_DIFF;
              end else if (st_i.extra_rem != '0) begin
                st_o.phase = PH_EXTRA;
              end else begin
                st_o.phase    = PH_CTRL;
                st_o.ctrl_idx = '0;
                addr_o        = fin_addr;
              end
            end
          end
        end
        PH_DIFF: begin
          valid            = 1'b1;
          byte_out         = src_byte_i + patch_byte_i;
          addr_o           = base_addr;
          st_o.dest_offset = st_i.dest_offset + 32'd1;
          st_o.diff_rem    = st_i.diff_rem - 32'd1;
          if (st_i.diff_rem == 32'd1) begin
            if (st_i.extra_rem != '0) begin
              st_o.phase = PH_EXTRA;
            end else begin
              st_o.phase    = PH_CTRL;
              st_o.ctrl_idx = '0;
              addr_o        = fin_addr;
            end
          end
        end
        PH_EXTRA: begin
          valid            = 1'b1;
          byte_out         = patch_byte_i;
          st_o.dest_offset = st_i.dest_offset + 32'd1;
          st_o.extra_rem   = st_i.extra_rem - 32'd1;
          if (st_i.extra_rem == 32'd1) begin
            st_o.phase    = PH_CTRL;
            st_o.ctrl_idx = '0;
            addr_o        = fin_addr;
          end
        end
        default: begin
          st_o = st_i;
        end
      endcase
    end
  end

  assign addr_ext = 64'(addr_o);

  // Report the state left behind by this item
  always_comb begin
    res_o.dest_valid       = valid;
    res_o.dest_byte        = byte_out;
    res_o.next_needs_src   = !st_o.error && (st_o.phase == PH_DIFF);
    res_o.next_src_addr    = addr_ext[31:0];
    res_o.done_res         = (st_o.phase == PH_CTRL) && (st_o.ctrl_idx == '0) &&
                             (st_o.dest_offset >= dest_size_i);
    res_o.status           = st_o.error;
    res_o.patch_bytes_used = st_o.patch_count;
  end

endmodule

// ===== src/binary_delta_patch_applier.sv =====
// ----------------------------------------------------------------------------
// binary_delta_patch_applier
// An accepted item's result is registered; the register frees as it is taken.
// Throughput: one item per cycle while the output is not stalled.
// Reset: asynchronous; state returns to control gathering, counters and
// dest_size clear, and the result register empties.
// ----------------------------------------------------------------------------
module binary_delta_patch_applier
  import bdpa_pkg::*;
#(
  parameter int unsigned ADDR_BITS = ADDR_BITS_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  bdpa_in_if.sink     in_i,
  bdpa_out_if.source  out_o
);

  state_t               st_q, st_d;
  logic [ADDR_BITS-1:0] addr_q, addr_d;
  logic [31:0]          dest_size_q;
  result_t              res_q, res_d;
  logic                 out_valid_q;
  logic                 accept;

  // Take a new item whenever the result register is empty or being drained
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  bdpa_step #(
    .ADDR_BITS (ADDR_BITS)
  ) u_step (
    .st_i         (st_q),
    .addr_i       (addr_q),
    .dest_size_i  (dest_size_q),
    .patch_byte_i (in_i.patch_byte),
    .src_byte_i   (in_i.src_byte),
    .st_o         (st_d),
    .addr_o       (addr_d),
    .res_o        (res_d)
  );

  // Hold the destination size
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_size_q <= '0;
    end else if (cfg_we_i) begin
      dest_size_q <= cfg_wdata_i;
    end
  end

  // Advance the block state on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= STATE_RESET;
      addr_q <= '0;
    end else if (accept) begin
      st_q   <= st_d;
      addr_q <= addr_d;
    end
  end

  // Result register valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.dest_valid       = res_q.dest_valid;
  assign out_o.dest_byte        = res_q.dest_byte;
  assign out_o.next_needs_src   = res_q.next_needs_src;
  assign out_o.next_src_addr    = res_q.next_src_addr;
  assign out_o.done_res         = res_q.done_res;
  assign out_o.status           = res_q.status;
  assign out_o.patch_bytes_used = res_q.patch_bytes_used;

endmodule

// ===== src/bdpa_chk.sv =====
// ----------------------------------------------------------------------------
// bdpa_chk
// Port-level checks for the delta patch applier, bound to the top level.
// ----------------------------------------------------------------------------
module bdpa_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        dest_valid_i,
  input logic [7:0]  dest_byte_i,
  input logic        next_needs_src_i,
  input logic        done_res_i,
  input logic        status_i,
  input logic [31:0] patch_bytes_used_i
);

  // Never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |-> !in_ready_i)
    else $error("input taken while result stalled");

  // Every accepted item shows a result on the next cycle
  a_item_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> out_valid_i)
    else $error("accepted item produced no result");

  // Bad data stops output and source requests, and is never done
  a_bad_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && status_i) |-> (!dest_valid_i && !next_needs_src_i && !done_res_i))
    else $error("activity after bad control data");

  // Hold a stalled result
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(dest_byte_i) && $stable(patch_bytes_used_i)))
    else $error("stalled result changed");

endmodule

bind binary_delta_patch_applier bdpa_chk u_bdpa_chk (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_i.valid),
  .in_ready_i         (in_i.ready),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .dest_valid_i       (out_o.dest_valid),
  .dest_byte_i        (out_o.dest_byte),
  .next_needs_src_i   (out_o.next_needs_src),
  .done_res_i         (out_o.done_res),
  .status_i           (out_o.status),
  .patch_bytes_used_i (out_o.patch_bytes_used)
);

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the delta patch applier. A generator builds patch
// streams of well-formed control blocks with random content, with some cut
// short, a few ignored bytes and one malformed block at the end. A clocked
// driver and monitor move items with random gaps and one long result stall.
// A local patch predictor works out each result as its item is accepted.
// ----------------------------------------------------------------------------
module tb_top;
  import bdpa_pkg::*;

  localparam logic [63:0] MAG_MASK     = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] NEG_ZERO     = 64'h8000_0000_0000_0000;
  localparam int          RANDOM_ITEMS = 1300;
  localparam int          GAP_PERCENT  = 8;
  localparam int          QUIET_FROM   = 600;
  localparam int          QUIET_TO     = 800;
  localparam int          HOLD_CYCLES  = 150;
  localparam int          STALL_LIMIT  = 4000;
  localparam int          MAX_REPORTS  = 40;

  typedef struct packed {
    logic [7:0] pb;
    logic [7:0] sb;
  } patch_item_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;

  bdpa_in_if  in_if ();
  bdpa_out_if out_if ();

  binary_delta_patch_applier dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // Predictor state
  phase_e      m_phase;
  logic [4:0]  m_idx;
  logic [63:0] m_shift;
  logic [63:0] m_diff;
  logic [63:0] m_extra;
  logic [31:0] m_off;
  logic [31:0] m_addr;
  logic [31:0] m_count;
  logic        m_err;
  logic [31:0] m_size;

  // Stimulus and scoreboard
  patch_item_t send_q[$];
  patch_item_t block_q[$];
  patch_item_t carry_q[$];
  result_t     dest_expect_q[$];
  patch_item_t drv_item;
  result_t     mon_want;
  logic [31:0] plan_off;
  int          n_in, n_out, n_dest, n_used, n_blocks, n_settings, errs;
  int          hold_left, stall_cycles;
  bit          hold_done, max_done;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---- Predictor -----------------------------------------------------------

  function automatic bit is_neg(input logic [63:0] v);
    return v[63] && (v[62:0] != '0);
  endfunction

  function automatic bit at_done();
    return m_phase == PH_CTRL && m_idx == '0 && m_off >= m_size;
  endfunction

  // Apply the seek and go back to gathering control bytes
  function automatic void close_block();
    if (is_neg(m_shift)) m_addr = m_addr - m_shift[31:0];
    else m_addr = m_addr + m_shift[31:0];
    m_phase = PH_CTRL;
    m_idx   = '0;
  endfunction

  function automatic result_t patch_step(input logic [7:0] pb, input logic [7:0] sb);
    result_t     r;
    logic [2:0]  pos;
    logic [63:0] room, dmag, emag;
    r = '0;
    if (!m_err && !at_done()) begin
      m_count++;
      case (m_phase)
        PH_CTRL: begin
          pos = m_idx[2:0];
          if (pos == 3'd0) m_shift = {56'h0, pb};
          else m_shift[8*pos +: 8] = pb;
          if (pos != POS_LAST) begin
            m_idx++;
          end else if (m_idx == IDX_DIFF_LAST) begin
            m_diff = m_shift;
            m_idx++;
          end else if (m_idx == IDX_EXTRA_LAST) begin
            m_extra = m_shift;
            m_idx++;
          end else begin
            // validate both lengths against what is left of the destination
            room  = (m_size > m_off) ? 64'(m_size - m_off) : 64'd0;
            dmag  = m_diff & MAG_MASK;
            emag  = m_extra & MAG_MASK;
            m_idx = IDX_SEEK_LAST;
            if (is_neg(m_diff) || is_neg(m_extra) || dmag > room || emag > room - dmag) begin
              m_err = 1'b1;
            end else begin
              m_diff  = dmag;
              m_extra = emag;
              if (m_diff != '0) m_phase = PH_DIFF;
              else if (m_extra != '0) m_phase = PH_EXTRA;
              else close_block();
            end
          end
        end
        PH_DIFF: begin
          r.dest_valid = 1'b1;
          r.dest_byte  = sb + pb;
          m_addr++;
          m_off++;
          m_diff--;
          if (m_diff == '0) begin
            if (m_extra != '0) m_phase = PH_EXTRA;
            else close_block();
          end
        end
        default: begin
          r.dest_valid = 1'b1;
          r.dest_byte  = pb;
          m_off++;
          m_extra--;
          if (m_extra == '0) close_block();
        end
      endcase
    end
    r.next_needs_src   = !m_err && m_phase == PH_DIFF;
    r.next_src_addr    = m_addr;
    r.done_res         = at_done();
    r.status           = m_err;
    r.patch_bytes_used = m_count;
    return r;
  endfunction

  // ---- Stimulus helpers ----------------------------------------------------

  function automatic bit take_gap();
    return (n_in < QUIET_FROM || n_in >= QUIET_TO) && ($urandom_range(0, 99) < GAP_PERCENT);
  endfunction

  function automatic patch_item_t rand_item();
    patch_item_t pi;
    pi.pb = 8'($urandom);
    pi.sb = 8'($urandom);
    return pi;
  endfunction

  // Length field: a zero length is sometimes sent as negative zero
  function automatic logic [63:0] len_code(input logic [63:0] v);
    if (v == '0 && $urandom_range(0, 3) == 0) return NEG_ZERO;
    return v;
  endfunction

  function automatic logic [63:0] rand_seek();
    logic [63:0] v;
    case ($urandom_range(0, 3))
      0:       v = 64'($urandom_range(0, 8));
      1:       v = 64'($urandom);
      2:       v = {$urandom, $urandom};
      default: v = NEG_ZERO;
    endcase
    if ($urandom_range(0, 1) != 0) v[63] = 1'b1;
    return v;
  endfunction

  // Append the 24 control bytes, little-endian, to the block under construction
  task automatic push_ctrl(input logic [63:0] diff, input logic [63:0] extra,
                           input logic [63:0] seek);
    logic [63:0] vals [3];
    patch_item_t pi;
    vals[0] = diff;
    vals[1] = extra;
    vals[2] = seek;
    for (int v = 0; v < 3; v++) begin
      for (int b = 0; b < 8; b++) begin
        pi    = rand_item();
        pi.pb = vals[v][8*b +: 8];
        block_q.push_back(pi);
      end
    end
  endtask

  // Send the first keep items of the block; hold the rest for the next chunk
  task automatic release_block(input int keep);
    for (int i = 0; i < block_q.size(); i++) begin
      if (i < keep) send_q.push_back(block_q[i]);
      else carry_q.push_back(block_q[i]);
    end
    block_q.delete();
  endtask

  task automatic send_carry();
    foreach (carry_q[i]) send_q.push_back(carry_q[i]);
    carry_q.delete();
  endtask

  task automatic wait_drained();
    while (send_q.size() != 0 || dest_expect_q.size() != 0 || in_if.valid) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [31:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    m_size = v;
    n_settings++;
  endtask

  // One chunk: maybe a new size, the rest of a cut block, then fresh blocks
  task automatic run_chunk();
    bit          boundary;
    logic [63:0] room, d, e;
    int          lim, nblk, keep;
    boundary = m_phase == PH_CTRL && m_idx == '0;
    if (boundary) begin
      if (!max_done && n_used > 800) begin
        max_done = 1'b1;
        cfg_write('1);
      end else if (m_off >= m_size) begin
        cfg_write(m_off + 32'($urandom_range(1, 60)));
      end else if ($urandom_range(0, 2) == 0) begin
        cfg_write(m_off + 32'($urandom_range(0, 60)));
      end
    end else if (m_phase != PH_CTRL && $urandom_range(0, 1) == 0) begin
      // lower the size under a running block; the block still completes
      cfg_write(m_off + 32'($urandom_range(0, 2)));
    end
    send_carry();
    room = (m_size > plan_off) ? 64'(m_size - plan_off) : 64'd0;
    nblk = $urandom_range(1, 4);
    for (int n = 0; n < nblk; n++) begin
      if (room == '0) begin
        // destination full: these bytes are ignored
        repeat ($urandom_range(1, 3)) send_q.push_back(rand_item());
        break;
      end
      lim = (room > 12) ? 12 : int'(room);
      d   = 64'($urandom_range(0, lim));
      lim = (room - d > 12) ? 12 : int'(room - d);
      e   = 64'($urandom_range(0, lim));
      if ($urandom_range(0, 5) == 0) e = (room - d > 20) ? e : room - d;
      push_ctrl(len_code(d), len_code(e), rand_seek());
      repeat (int'(d + e)) block_q.push_back(rand_item());
      plan_off += 32'(d + e);
      room     -= d + e;
      n_used   += block_q.size();
      n_blocks++;
      if (n == nblk - 1 && $urandom_range(0, 3) == 0) keep = $urandom_range(1, block_q.size() - 1);
      else keep = block_q.size();
      release_block(keep);
    end
    wait_drained();
  endtask

  // ---- Driver --------------------------------------------------------------

  // Predict at acceptance; offer the next item when the slot frees
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        dest_expect_q.push_back(patch_step(in_if.patch_byte, in_if.src_byte));
        n_in++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (send_q.size() != 0 && !take_gap()) begin
          drv_item = send_q.pop_front();
          in_if.valid      <= 1'b1;
          in_if.patch_byte <= drv_item.pb;
          in_if.src_byte   <= drv_item.sb;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---- Monitor -------------------------------------------------------------

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      errs++;
      if (errs <= MAX_REPORTS) $error("%s: expected %0h, got %0h", name, want, got);
    end
  endtask

  // Compare each taken result with the oldest prediction; stall at random
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        n_out++;
        if (dest_expect_q.size() == 0) begin
          errs++;
          if (errs <= MAX_REPORTS) $error("result taken with no prediction waiting");
        end else begin
          mon_want = dest_expect_q.pop_front();
          if (mon_want.dest_valid) n_dest++;
          check_field("dest_valid", 32'(mon_want.dest_valid), 32'(out_if.dest_valid));
          check_field("dest_byte", 32'(mon_want.dest_byte), 32'(out_if.dest_byte));
          check_field("next_needs_src", 32'(mon_want.next_needs_src),
                      32'(out_if.next_needs_src));
          check_field("next_src_addr", mon_want.next_src_addr, out_if.next_src_addr);
          check_field("done_res", 32'(mon_want.done_res), 32'(out_if.done_res));
          check_field("status", 32'(mon_want.status), 32'(out_if.status));
          check_field("patch_bytes_used", mon_want.patch_bytes_used,
                      out_if.patch_bytes_used);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (!hold_done && n_out >= 300 && send_q.size() > 20) begin
        // hold off while the sender keeps offering, so the input backs up
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= !take_gap();
      end
    end
  end

  // ---- Watchdog ------------------------------------------------------------

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("tb_top: done, errors");
          $finish;
        end
      end
    end
  end

  // ---- Sequence ------------------------------------------------------------

  initial begin
    logic [63:0] room, d, e;
    patch_item_t pi;
    int          kind;

    // initialise predictor and inputs
    m_phase = PH_CTRL;  m_idx = '0;   m_shift = '0;  m_diff = '0;  m_extra = '0;
    m_off = '0;  m_addr = '0;  m_count = '0;  m_err = 1'b0;  m_size = '0;
    plan_off = '0;
    n_in = 0;  n_out = 0;  n_dest = 0;  n_used = 0;  n_blocks = 0;  n_settings = 0;
    errs = 0;  hold_left = 0;  stall_cycles = 0;  hold_done = 1'b0;  max_done = 1'b0;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = '0;
    in_if.valid      = 1'b0;
    in_if.patch_byte = '0;
    in_if.src_byte   = '0;
    out_if.ready     = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // zero size: done at once, bytes ignored and not counted
    cfg_write('0);
    send_q.push_back(patch_item_t'{pb: 8'h00, sb: 8'h00});
    send_q.push_back(patch_item_t'{pb: 8'hff, sb: 8'hff});
    wait_drained();

    // one diff byte whose sum wraps, negative zero extra, backward seek
    cfg_write(32'd10);
    push_ctrl(64'd1, NEG_ZERO, {1'b1, 63'd3});
    block_q.push_back(patch_item_t'{pb: 8'hff, sb: 8'hff});
    plan_off = 32'd1;
    n_blocks++;
    release_block(block_q.size());
    wait_drained();

    while (n_used < RANDOM_ITEMS) run_chunk();

    // finish any cut block, make room, then send one malformed block
    send_carry();
    wait_drained();
    if (m_off >= m_size) cfg_write(m_off + 32'd16);
    room = 64'(m_size - m_off);
    kind = $urandom_range(0, 3);
    d    = 64'($urandom_range(0, 6));
    e    = 64'($urandom_range(0, 6));
    case (kind)
      0:       d = {1'b1, 63'($urandom_range(1, 40))};
      1:       e = {1'b1, 63'($urandom_range(1, 40))};
      2:       d = ($urandom_range(0, 1) != 0) ? MAG_MASK : room + 64'($urandom_range(1, 5));
      default: begin
        d = (room > 6) ? d : room;
        e = room - d + 64'($urandom_range(1, 3));
      end
    endcase
    push_ctrl(d, e, rand_seek());
    n_blocks++;
    release_block(block_q.size());
    // bad data is sticky: everything after is ignored
    repeat (6) begin
      pi = rand_item();
      send_q.push_back(pi);
    end
    wait_drained();
    repeat (4) @(posedge clk_i);

    $display("tb_top: %0d items sent, %0d results checked, %0d destination bytes",
             n_in, n_out, n_dest);
    $display("tb_top: %0d control blocks over %0d size settings, bad block kind %0d",
             n_blocks, n_settings, kind);
    if (errs == 0 && dest_expect_q.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
